/* sv/ik_pkg.sv */
// shared constants, widths, tag structs and the arctangent table for the arm ik block
// no dependencies; imported by every module of the block
package ik_pkg;

   localparam int XW = 20;               // input coordinate width
   localparam int SUM_W = XW + 1;        // coordinate plus offset
   localparam int LEN_W = 17;            // link length and offset registers
   localparam int SHOFF_W = 14;          // shoulder zero offset register
   localparam int CSR_IDX_W = 3;
   localparam int OUT_W = 16;            // output angles
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN = 24;

   localparam int ANG_W = 25;            // internal angle in 2^-20 rad
   localparam int YAW_W = 32;            // cordic width for the base yaw pass
   localparam int SH1_W = 32;            // cordic width for atan2(z, r)
   localparam int EL_W = 27;             // cordic width for atan2(s, c)
   localparam int SH2_W = 46;            // cordic width for the second shoulder term
   localparam int MAG_W = 31;
   localparam int GAIN_W = 30;
   localparam int PROD_W = MAG_W + GAIN_W;
   localparam int R24_W = 30;
   localparam int R16_W = 21;
   localparam int DEN_W = 35;
   localparam int NUM_W = 44;
   localparam int Q_W = 25;              // quotient bits, c magnitude
   localparam int DIVN_W = DEN_W + Q_W;
   localparam int C_W = Q_W + 1;
   localparam int ROOT_W = 25;
   localparam int RAD_W = 2 * ROOT_W;

   localparam logic signed [ANG_W-1:0] ANG_PI = 25'sd3294199;
   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
   localparam logic [PROD_W-1:0] GAIN_HALF = 61'd536870912;
   localparam logic [RAD_W-1:0] RAD_ONE = 50'h1_0000_0000_0000;

   localparam logic [LEN_W-1:0] L1_RST = 17'd13763;
   localparam logic [LEN_W-1:0] L2_RST = 17'd21627;
   localparam logic signed [LEN_W-1:0] XOFF_RST = -17'sd98;
   localparam logic signed [LEN_W-1:0] YOFF_RST = 17'sd3473;
   localparam logic [SHOFF_W-1:0] SHOFF_RST = 14'd6431;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_L1    = 3'd0,
      CSR_L2    = 3'd1,
      CSR_XOFF  = 3'd2,
      CSR_YOFF  = 3'd3,
      CSR_SHOFF = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] yaw;
      logic [R24_W-1:0]        r24;
      logic signed [XW-1:0]    z;
      logic                    unreach;
      logic                    neg;
   } div_tag_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] yaw;
      logic [R24_W-1:0]        r24;
      logic signed [XW-1:0]    z;
      logic                    unreach;
      logic signed [C_W-1:0]   c;
   } sqrt_tag_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] yaw;
      logic                    unreach;
   } el_tag_type;

   // arctangent of 2^-i in 2^-20 rad
   function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0: v = 25'sd823550;
         1: v = 25'sd486170;
         2: v = 25'sd256879;
         3: v = 25'sd130396;
         4: v = 25'sd65451;
         5: v = 25'sd32757;
         6: v = 25'sd16383;
         7: v = 25'sd8192;
         8: v = 25'sd4096;
         9: v = 25'sd2048;
         10: v = 25'sd1024;
         11: v = 25'sd512;
         12: v = 25'sd256;
         13: v = 25'sd128;
         14: v = 25'sd64;
         15: v = 25'sd32;
         16: v = 25'sd16;
         17: v = 25'sd8;
         18: v = 25'sd4;
         19: v = 25'sd2;
         20: v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* sv/ik_if.sv */
// request and response channel interfaces of the arm ik block
// depends on ik_pkg for field widths
interface ik_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [ik_pkg::XW-1:0]    target_x;
   logic signed [ik_pkg::XW-1:0]    target_y;
   logic signed [ik_pkg::XW-1:0]    target_z;

   modport source (output valid, target_x, target_y, target_z, input ready);
   modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface ik_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [ik_pkg::OUT_W-1:0] base_yaw;
   logic signed [ik_pkg::OUT_W-1:0] shoulder_angle;
   logic signed [ik_pkg::OUT_W-1:0] elbow_angle;
   logic                            unreachable;

   modport source (output valid, base_yaw, shoulder_angle, elbow_angle, unreachable,
                   input ready);
   modport sink (input valid, base_yaw, shoulder_angle, elbow_angle, unreachable,
                 output ready);
endinterface

/* sv/ik_cordic.sv */
// pipelined vectoring cordic: atan2(b, a) and raw magnitude, one stage per iteration
// depends on ik_pkg for the arctangent table and pi
module ik_cordic #(
   parameter int STAGES = ik_pkg::CORDIC_STAGES_DEF,
   parameter int W = 32,
   parameter int TAG_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic signed [W-1:0]             in_a,
   input  logic signed [W-1:0]             in_b,
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_vld,
   output logic signed [W-1:0]             out_mag,
   output logic signed [ik_pkg::ANG_W-1:0] out_ang,
   output logic [TAG_W-1:0]                out_tag
);
   import ik_pkg::*;

   logic signed [W-1:0]     a_ff [STAGES+1];
   logic signed [W-1:0]     b_ff [STAGES+1];
   logic signed [ANG_W-1:0] z_ff [STAGES+1];
   logic                    zero_ff [STAGES+1];
   logic [TAG_W-1:0]        tag_ff [STAGES+1];
   logic [STAGES:0]         vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-1:0], in_vld};
      end
   end

   // left half plane is turned by pi first
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]    <= (in_a < 0) ? -in_a : in_a;
         b_ff[0]    <= (in_a < 0) ? -in_b : in_b;
         z_ff[0]    <= (in_a < 0) ? ((in_b >= 0) ? ANG_PI : -ANG_PI) : '0;
         zero_ff[0] <= (in_a == 0) && (in_b == 0);
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            if (b_ff[i] > 0) begin
               a_ff[i+1] <= a_ff[i] + (b_ff[i] >>> i);
               b_ff[i+1] <= b_ff[i] - (a_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end else begin
               a_ff[i+1] <= a_ff[i] - (b_ff[i] >>> i);
               b_ff[i+1] <= b_ff[i] + (a_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end
            zero_ff[i+1] <= zero_ff[i];
            tag_ff[i+1]  <= tag_ff[i];
         end
      end
   end

   assign out_vld = vld_ff[STAGES];
   assign out_mag = zero_ff[STAGES] ? '0 : a_ff[STAGES];
   assign out_ang = zero_ff[STAGES] ? '0 : z_ff[STAGES];
   assign out_tag = tag_ff[STAGES];

endmodule

/* sv/ik_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on ik_pkg for widths; quotient must fit in Q_W bits
module ik_div #(
   parameter int TAG_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_vld,
   input  logic [ik_pkg::DIVN_W-1:0]        in_num,
   input  logic [ik_pkg::DEN_W-1:0]         in_den,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_vld,
   output logic [ik_pkg::Q_W-1:0]           out_quo,
   output logic [TAG_W-1:0]                 out_tag
);
   import ik_pkg::*;

   logic [DEN_W-1:0]  rem_ff [Q_W];
   logic [DIVN_W-1:0] num_ff [Q_W];
   logic [DEN_W-1:0]  den_ff [Q_W];
   logic [Q_W-1:0]    quo_ff [Q_W];
   logic [TAG_W-1:0]  tag_ff [Q_W];
   logic [Q_W-1:0]    vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Q_W-2:0], in_vld};
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DEN_W-1:0]  rem_prev;
      logic [DIVN_W-1:0] num_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [DEN_W:0]    trial;
      logic              ge;

      if (k == 0) begin : g_first
         // the high part of the numerator is already below the divisor
         assign rem_prev = in_num[DIVN_W-1 -: DEN_W];
         assign num_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      assign trial = {rem_prev, num_prev[Q_W-1-k]};
      assign ge = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
            quo_ff[k] <= {quo_prev[Q_W-2:0], ge};
            num_ff[k] <= num_prev;
            den_ff[k] <= den_prev;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_vld = vld_ff[Q_W-1];
   assign out_quo = quo_ff[Q_W-1];
   assign out_tag = tag_ff[Q_W-1];

endmodule

/* sv/ik_isqrt.sv */
// pipelined integer square root, one root bit per stage (floor)
// depends on ik_pkg for widths
module ik_isqrt #(
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [ik_pkg::RAD_W-1:0]    in_rad,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_vld,
   output logic [ik_pkg::ROOT_W-1:0]   out_root,
   output logic [TAG_W-1:0]            out_tag
);
   import ik_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_ff [ROOT_W];
   logic [ROOT_W-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_vld};
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  test;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = in_rad;
         assign root_prev = '0;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      // bring down the next bit pair, try root*4 + 1
      assign cur  = {rem_prev, rad_prev[RAD_W-1-2*k -: 2]};
      assign test = (REM_W+2)'({root_prev, 2'b01});
      assign ge   = cur >= test;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(cur - test) : cur[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            rad_ff[k]  <= rad_prev;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_tag  = tag_ff[ROOT_W-1];

endmodule

/* sv/two_link_arm_inverse_kinematics.sv */
// two-link arm inverse kinematics with base yaw; accepts one word per cycle unless stalled.
// from request to response a word runs through two cordic passes, the 25-stage divider
// and the 25-stage square root, with registered stages between them.
// a stalled response holds the pipeline only once its last stage is full.
// synchronous active-high reset clears all valid bits and loads the register defaults.
module two_link_arm_inverse_kinematics #(
   parameter int CORDIC_STAGES = ik_pkg::CORDIC_STAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ik_req_if.sink                         req_ch,
   ik_rsp_if.source                       rsp_ch,
   input  logic                           csr_we,
   input  logic [ik_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ik_pkg::LEN_W-1:0]       csr_data
);
   import ik_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]          l1_ff;
   logic [LEN_W-1:0]          l2_ff;
   logic signed [LEN_W-1:0]   xoff_ff;
   logic signed [LEN_W-1:0]   yoff_ff;
   logic [SHOFF_W-1:0]        shoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff    <= L1_RST;
         l2_ff    <= L2_RST;
         xoff_ff  <= XOFF_RST;
         yoff_ff  <= YOFF_RST;
         shoff_ff <= SHOFF_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_L1:    l1_ff <= csr_data;
            CSR_L2:    l2_ff <= csr_data;
            CSR_XOFF:  xoff_ff <= csr_data;
            CSR_YOFF:  yoff_ff <= csr_data;
            CSR_SHOFF: shoff_ff <= csr_data[SHOFF_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_take;
   logic fin_vld_ff;
   logic out_vld_ff;

   assign out_take = !out_vld_ff || rsp_ch.ready;
   assign adv = out_take || !fin_vld_ff;
   assign req_ch.ready = adv;

   // stage 0: offsets
   logic                     v0_ff;
   logic signed [SUM_W-1:0]  x0_ff;
   logic signed [SUM_W-1:0]  y0_ff;
   logic signed [XW-1:0]     z0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= SUM_W'(req_ch.target_x) + SUM_W'(xoff_ff);
         y0_ff <= SUM_W'(req_ch.target_y) + SUM_W'(yoff_ff);
         z0_ff <= req_ch.target_z;
      end
   end

   // base yaw and radius
   logic                     c1_vld;
   logic signed [YAW_W-1:0]  c1_mag;
   logic signed [ANG_W-1:0]  c1_ang;
   logic [XW-1:0]            c1_tag;

   ik_cordic #(.STAGES(CORDIC_STAGES), .W(YAW_W), .TAG_W(XW)) u_yaw (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v0_ff),
      .in_a    (YAW_W'(x0_ff) <<< 8),
      .in_b    (YAW_W'(y0_ff) <<< 8),
      .in_tag  (z0_ff),
      .out_vld (c1_vld),
      .out_mag (c1_mag),
      .out_ang (c1_ang),
      .out_tag (c1_tag)
   );

   // stages 2 to 6: gain correction, squares, cosine numerator and divisor
   logic                     v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [PROD_W-1:0]        p2_ff;
   logic signed [ANG_W-1:0]  yaw2_ff, yaw3_ff, yaw4_ff, yaw5_ff, yaw6_ff;
   logic signed [XW-1:0]     z2_ff, z3_ff, z4_ff, z5_ff, z6_ff;
   logic [R24_W-1:0]         r3_ff, r4_ff, r5_ff, r6_ff;
   logic [2*R16_W-1:0]       r16sq4_ff;
   logic [2*XW-1:0]          zsq4_ff;
   logic [2*LEN_W-1:0]       l1sq4_ff, l2sq4_ff;
   logic [DEN_W-1:0]         den4_ff, den5_ff, den6_ff;
   logic signed [NUM_W-1:0]  num5_ff;
   logic [DIVN_W-1:0]        divn6_ff;
   logic                     unreach6_ff, neg6_ff;
   logic [R16_W-1:0]         r16;
   logic [NUM_W-1:0]         num_mag;

   assign r16 = R16_W'(((R24_W+1)'(r3_ff) + (R24_W+1)'(128)) >> 8);
   assign num_mag = (num5_ff < 0) ? NUM_W'(-num5_ff) : NUM_W'(num5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= c1_vld;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff   <= c1_mag[MAG_W-1:0] * INV_GAIN;
         yaw2_ff <= c1_ang;
         z2_ff   <= c1_tag;

         r3_ff   <= R24_W'((p2_ff + GAIN_HALF) >> 30);
         yaw3_ff <= yaw2_ff;
         z3_ff   <= z2_ff;

         r4_ff     <= r3_ff;
         yaw4_ff   <= yaw3_ff;
         z4_ff     <= z3_ff;
         r16sq4_ff <= r16 * r16;
         zsq4_ff   <= z3_ff * z3_ff;
         l1sq4_ff  <= l1_ff * l1_ff;
         l2sq4_ff  <= l2_ff * l2_ff;
         den4_ff   <= (l1_ff * l2_ff) << 1;

         num5_ff <= $signed(NUM_W'(r16sq4_ff)) + $signed(NUM_W'(zsq4_ff))
                    - $signed(NUM_W'(l1sq4_ff)) - $signed(NUM_W'(l2sq4_ff));
         den5_ff <= den4_ff;
         r5_ff   <= r4_ff;
         yaw5_ff <= yaw4_ff;
         z5_ff   <= z4_ff;

         // rounding half of the divisor is folded into the dividend
         unreach6_ff <= (den5_ff == '0) || ((NUM_W+1)'(num_mag) > (NUM_W+1)'(den5_ff));
         neg6_ff     <= num5_ff < 0;
         divn6_ff    <= DIVN_W'({num_mag, 24'd0}) + DIVN_W'(den5_ff >> 1);
         den6_ff     <= den5_ff;
         r6_ff       <= r5_ff;
         yaw6_ff     <= yaw5_ff;
         z6_ff       <= z5_ff;
      end
   end

   // elbow cosine
   div_tag_type div_tag_in, div_tag_out;
   logic                div_vld;
   logic [Q_W-1:0]      div_quo;

   assign div_tag_in = '{yaw: yaw6_ff, r24: r6_ff, z: z6_ff, unreach: unreach6_ff,
                         neg: neg6_ff};

   ik_div #(.TAG_W($bits(div_tag_type))) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v6_ff),
      .in_num  (divn6_ff),
      .in_den  (den6_ff),
      .in_tag  (div_tag_in),
      .out_vld (div_vld),
      .out_quo (div_quo),
      .out_tag (div_tag_out)
   );

   // stage 7: signed cosine and 1 - c^2
   logic                    v7_ff;
   sqrt_tag_type            sq_tag7_ff;
   logic [RAD_W-1:0]        rad7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_tag7_ff.yaw     <= div_tag_out.yaw;
         sq_tag7_ff.r24     <= div_tag_out.r24;
         sq_tag7_ff.z       <= div_tag_out.z;
         sq_tag7_ff.unreach <= div_tag_out.unreach;
         sq_tag7_ff.c       <= div_tag_out.neg ? -$signed({1'b0, div_quo})
                                               : $signed({1'b0, div_quo});
         rad7_ff            <= RAD_ONE - (RAD_W'(div_quo) * RAD_W'(div_quo));
      end
   end

   // elbow sine
   sqrt_tag_type            sq_tag_out;
   logic                    sq_vld;
   logic [ROOT_W-1:0]       sq_root;

   ik_isqrt #(.TAG_W($bits(sqrt_tag_type))) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (v7_ff),
      .in_rad   (rad7_ff),
      .in_tag   (sq_tag7_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_tag  (sq_tag_out)
   );

   // stage 9: operands of the three angle passes
   logic                    v9_ff;
   el_tag_type              el_tag9_ff;
   logic signed [EL_W-1:0]  el_a9_ff, el_b9_ff;
   logic signed [SH1_W-1:0] sh1_a9_ff, sh1_b9_ff;
   logic signed [SH2_W-1:0] sh2_a9_ff, sh2_b9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         el_tag9_ff.yaw     <= sq_tag_out.yaw;
         el_tag9_ff.unreach <= sq_tag_out.unreach;
         el_a9_ff  <= EL_W'(sq_tag_out.c);
         el_b9_ff  <= EL_W'($signed({1'b0, sq_root}));
         sh1_a9_ff <= SH1_W'($signed({1'b0, sq_tag_out.r24}));
         sh1_b9_ff <= SH1_W'(sq_tag_out.z) <<< 8;
         sh2_a9_ff <= $signed({1'b0, l1_ff, 24'd0})
                      + $signed({1'b0, l2_ff}) * sq_tag_out.c;
         sh2_b9_ff <= $signed({1'b0, l2_ff}) * $signed({1'b0, sq_root});
      end
   end

   el_tag_type              el_tag;
   logic                    el_vld, sh1_vld, sh2_vld;
   logic                    sh1_tag, sh2_tag;
   logic signed [ANG_W-1:0] el_ang, sh1_ang, sh2_ang;

   ik_cordic #(.STAGES(CORDIC_STAGES), .W(EL_W), .TAG_W($bits(el_tag_type))) u_elbow (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v9_ff),
      .in_a    (el_a9_ff),
      .in_b    (el_b9_ff),
      .in_tag  (el_tag9_ff),
      .out_vld (el_vld),
      .out_mag (),
      .out_ang (el_ang),
      .out_tag (el_tag)
   );

   ik_cordic #(.STAGES(CORDIC_STAGES), .W(SH1_W), .TAG_W(1)) u_sh_elev (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v9_ff),
      .in_a    (sh1_a9_ff),
      .in_b    (sh1_b9_ff),
      .in_tag  (el_tag9_ff.unreach),
      .out_vld (sh1_vld),
      .out_mag (),
      .out_ang (sh1_ang),
      .out_tag (sh1_tag)
   );

   ik_cordic #(.STAGES(CORDIC_STAGES), .W(SH2_W), .TAG_W(1)) u_sh_link (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v9_ff),
      .in_a    (sh2_a9_ff),
      .in_b    (sh2_b9_ff),
      .in_tag  (el_tag9_ff.unreach),
      .out_vld (sh2_vld),
      .out_mag (),
      .out_ang (sh2_ang),
      .out_tag (sh2_tag)
   );

   // final stage: round to 2^-12 rad, apply shoulder zero offset and zero the arm angles of unreachable words
   logic signed [ANG_W:0]    sh_sum;
   logic signed [ANG_W:0]    sh_round;
   logic signed [ANG_W-1:0]  el_round;
   logic signed [ANG_W-1:0]  yaw_round;
   logic signed [ANG_W:0]    sh_out;
   logic signed [OUT_W-1:0]  fin_yaw_ff, fin_sh_ff, fin_el_ff;
   logic                     fin_unreach_ff;
   logic signed [OUT_W-1:0]  out_yaw_ff, out_sh_ff, out_el_ff;
   logic                     out_unreach_ff;

   assign sh_sum    = (ANG_W+1)'(sh1_ang) + (ANG_W+1)'(sh2_ang);
   assign sh_round  = (sh_sum + (ANG_W+1)'(128)) >>> 8;
   assign el_round  = (el_ang + ANG_W'(128)) >>> 8;
   assign yaw_round = (el_tag.yaw + ANG_W'(128)) >>> 8;
   assign sh_out    = $signed((ANG_W+1)'(shoff_ff)) - sh_round;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            fin_vld_ff <= el_vld;
         end
         if (out_take) begin
            out_vld_ff <= fin_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_yaw_ff     <= yaw_round[OUT_W-1:0];
         fin_sh_ff      <= el_tag.unreach ? '0 : sh_out[OUT_W-1:0];
         fin_el_ff      <= el_tag.unreach ? '0 : el_round[OUT_W-1:0];
         fin_unreach_ff <= el_tag.unreach;
      end
      if (out_take) begin
         out_yaw_ff     <= fin_yaw_ff;
         out_sh_ff      <= fin_sh_ff;
         out_el_ff      <= fin_el_ff;
         out_unreach_ff <= fin_unreach_ff;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.base_yaw       = out_yaw_ff;
   assign rsp_ch.shoulder_angle = out_sh_ff;
   assign rsp_ch.elbow_angle    = out_el_ff;
   assign rsp_ch.unreachable    = out_unreach_ff;

`ifndef ASSERT_OFF
   // the three parallel angle passes stay in lockstep
   assert property (@(posedge clock) disable iff (reset)
      (el_vld == sh1_vld) && (el_vld == sh2_vld))
      else $error("angle pipes out of step");

   assert property (@(posedge clock) disable iff (reset)
      el_vld |-> (sh1_tag == el_tag.unreach) && (sh2_tag == el_tag.unreach))
      else $error("reach flag differs between angle pipes");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_unreach_ff) |-> (out_sh_ff == '0) && (out_el_ff == '0))
      else $error("unreachable word carries arm angles");

   assert property (@(posedge clock) disable iff (reset)
      (fin_vld_ff && !adv) |=> fin_vld_ff)
      else $error("last stage dropped a word while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> !out_vld_ff)
      else $error("response valid right after reset");
`endif

endmodule
